>>> rtl/psu_pkg.sv
// Shared types, constants and saturation helpers for the particle state update pipeline.
package psu_pkg;

  localparam int unsigned PosW     = 40;
  localparam int unsigned LifeW    = 32;
  localparam int unsigned DtW      = 17;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned MaxLifeW = 31;
  localparam int unsigned QuoW     = 16;

  localparam logic [DtW-1:0]  FrameStepReset = 17'd1092;
  localparam logic [CfgW-1:0] GravityYReset  = 32'hFFF6_3334;
  localparam logic [DtW:0]    OneQ16         = 18'd65536;
  localparam logic [15:0]     NineTenthsQ16  = 16'd58982;
  localparam logic signed [63:0] ParkYQ16    = -64'sd6553534464;

  typedef enum logic [2:0] {
    CFG_FRAME_STEP = 3'd0,
    CFG_GRAVITY_X  = 3'd1,
    CFG_GRAVITY_Y  = 3'd2,
    CFG_GRAVITY_Z  = 3'd3,
    CFG_WIND_X     = 3'd4,
    CFG_WIND_Y     = 3'd5,
    CFG_WIND_Z     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                       alive;
    logic                       live;
    logic [LifeW-1:0]           life;
    logic [2:0][PosW-1:0]       pos;
    logic [2:0][PosW-1:0]       vel;
    logic [LifeW-1:0]           size;
  } rec_t;

  function automatic logic [PosW-1:0] sat40(input logic signed [63:0] x);
    if (x > 64'sd549755813887) begin
      return 40'h7F_FFFF_FFFF;
    end else if (x < -64'sd549755813888) begin
      return 40'h80_0000_0000;
    end
    return x[PosW-1:0];
  endfunction

  function automatic logic [LifeW-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[LifeW-1:0];
  endfunction

endpackage

>>> rtl/particle_state_update.sv
// Top level of the particle state update pipeline: one frame step per particle record.
//
// Particle records enter on the input channel (valid_i, stall_o) and leave
// advanced by one frame step on the output channel (valid_o, stall_i).
// A transfer happens on a rising edge with valid high and stall low.
// The pipeline takes one record per cycle unless the receiver stalls, and
// returns records in order. The depth is set by the 16-step ratio divider plus
// the multiply chain around it. Configuration registers are written through
// cfg_we_i, cfg_idx_i and cfg_data_i; the user must write them only while the
// pipeline is empty, as the block does not enforce this. Unknown indexes are ignored.
// Reset empties the pipeline and loads the default step, gravity and wind.
// When the receiver stalls a waiting result, the whole pipeline holds and
// stall_o is raised, so nothing is lost or repeated.
module particle_state_update (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic                 alive_in_i,
  input  logic signed [31:0]   life_in_i,
  input  logic [30:0]          max_life_i,
  input  logic signed [39:0]   pos_x_in_i,
  input  logic signed [39:0]   pos_y_in_i,
  input  logic signed [39:0]   pos_z_in_i,
  input  logic signed [39:0]   vel_x_in_i,
  input  logic signed [39:0]   vel_y_in_i,
  input  logic signed [39:0]   vel_z_in_i,
  input  logic [30:0]          drag_coef_i,
  input  logic signed [31:0]   size_in_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic                 alive_out_o,
  output logic signed [31:0]   life_out_o,
  output logic signed [39:0]   pos_x_out_o,
  output logic signed [39:0]   pos_y_out_o,
  output logic signed [39:0]   pos_z_out_o,
  output logic signed [39:0]   vel_x_out_o,
  output logic signed [39:0]   vel_y_out_o,
  output logic signed [39:0]   vel_z_out_o,
  output logic signed [31:0]   size_out_o
);

  localparam int unsigned Last = 21;

  logic [psu_pkg::DtW-1:0] dt_q;
  logic [31:0]             grav_q [3];
  logic [31:0]             wind_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q      <= psu_pkg::FrameStepReset;
      grav_q[0] <= '0;
      grav_q[1] <= psu_pkg::GravityYReset;
      grav_q[2] <= '0;
      wind_q[0] <= '0;
      wind_q[1] <= '0;
      wind_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psu_pkg::CFG_FRAME_STEP: dt_q      <= cfg_data_i[psu_pkg::DtW-1:0];
        psu_pkg::CFG_GRAVITY_X:  grav_q[0] <= cfg_data_i;
        psu_pkg::CFG_GRAVITY_Y:  grav_q[1] <= cfg_data_i;
        psu_pkg::CFG_GRAVITY_Z:  grav_q[2] <= cfg_data_i;
        psu_pkg::CFG_WIND_X:     wind_q[0] <= cfg_data_i;
        psu_pkg::CFG_WIND_Y:     wind_q[1] <= cfg_data_i;
        psu_pkg::CFG_WIND_Z:     wind_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic [Last:0] vld_q;

  assign en      = !(vld_q[Last] && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Last-1:0], valid_i};
    end
  end

  // Input stage.
  logic        alive0_q;
  logic [31:0] life0_q;
  logic [30:0] maxl0_q;
  logic [30:0] drag0_q;
  logic [2:0][39:0] pos0_q;
  logic [2:0][39:0] vel0_q;
  logic [31:0] size0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      alive0_q <= alive_in_i;
      life0_q  <= life_in_i;
      maxl0_q  <= max_life_i;
      drag0_q  <= drag_coef_i;
      pos0_q   <= {pos_z_in_i, pos_y_in_i, pos_x_in_i};
      vel0_q   <= {vel_z_in_i, vel_y_in_i, vel_x_in_i};
      size0_q  <= size_in_i;
    end
  end

  psu_pkg::rec_t rec_d [1:Last];
  psu_pkg::rec_t rec_q [1:Last];

  logic signed [32:0] acc1_d [3];
  logic signed [32:0] acc1_q [3];
  logic [47:0]        dd1_d, dd1_q;
  logic [30:0]        maxl1_q;
  logic signed [33:0] k2_d, k2_q, k3_q;
  logic signed [50:0] ad2_d [3];
  logic signed [50:0] ad2_q [3];
  logic [39:0]        v1_d [3];
  logic [39:0]        v1_q [3];
  logic signed [56:0] lo4_d [3];
  logic signed [56:0] lo4_q [3];
  logic signed [57:0] hi4_d [3];
  logic signed [57:0] hi4_q [3];
  logic signed [57:0] pv6_d [3];
  logic signed [57:0] pv6_q [3];
  logic [psu_pkg::QuoW:0] q18;
  logic [32:0]        r19_d, r19_q;
  logic signed [49:0] sz20_d, sz20_q;
  logic [31:0]        life_dec;
  logic [17:0]        ratio18;
  logic [17:0]        s20;

  always_comb begin
    life_dec = psu_pkg::sat32(64'(signed'(life0_q)) - 64'({1'b0, dt_q}));
    rec_d[1].alive = alive0_q;
    rec_d[1].live  = 1'b0;
    rec_d[1].life  = life0_q;
    rec_d[1].pos   = pos0_q;
    rec_d[1].vel   = vel0_q;
    rec_d[1].size  = size0_q;
    if (alive0_q) begin
      rec_d[1].life = life_dec;
      if (signed'(life_dec) <= 32'sd0) begin
        rec_d[1].alive  = 1'b0;
        rec_d[1].pos[0] = '0;
        rec_d[1].pos[1] = psu_pkg::ParkYQ16[39:0];
        rec_d[1].pos[2] = '0;
      end else begin
        rec_d[1].live = 1'b1;
      end
    end
    dd1_d = 48'(drag0_q) * 48'(dt_q);
    k2_d  = 34'(psu_pkg::OneQ16) - 34'(dd1_q[47:16]);
    for (int i = 0; i < 3; i++) begin
      acc1_d[i] = 33'(signed'(grav_q[i])) + 33'(signed'(wind_q[i]));
      ad2_d[i]  = 51'(acc1_q[i]) * 51'(signed'({1'b0, dt_q}));
      v1_d[i]   = psu_pkg::sat40(64'(signed'(rec_q[2].vel[i])) +
                                 64'(signed'(ad2_q[i][50:16])));
      lo4_d[i]  = 57'(signed'(v1_q[i])) * 57'(signed'({1'b0, k3_q[15:0]}));
      hi4_d[i]  = 58'(signed'(v1_q[i])) * 58'(signed'(k3_q[33:16]));
      pv6_d[i]  = 58'(signed'(rec_q[5].vel[i])) * 58'(signed'({1'b0, dt_q}));
    end
    for (int j = 2; j <= Last; j++) begin
      rec_d[j] = rec_q[j-1];
    end
    for (int i = 0; i < 3; i++) begin
      if (rec_q[4].live) begin
        rec_d[5].vel[i] = psu_pkg::sat40(64'(hi4_q[i]) + 64'(signed'(lo4_q[i][56:16])));
      end
      if (rec_q[6].live) begin
        rec_d[7].pos[i] = psu_pkg::sat40(64'(signed'(rec_q[6].pos[i])) +
                                         64'(signed'(pv6_q[i][57:16])));
      end
    end
    ratio18 = psu_pkg::OneQ16 - 18'(q18);
    r19_d   = 33'(psu_pkg::NineTenthsQ16) * 33'(ratio18);
    s20     = psu_pkg::OneQ16 - 18'(r19_q[32:16]);
    sz20_d  = 50'(signed'(rec_q[19].size)) * 50'(signed'({1'b0, s20}));
    if (rec_q[20].live) begin
      rec_d[21].size = psu_pkg::sat32(64'(signed'(sz20_q[49:16])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 1; j <= Last; j++) begin
        rec_q[j] <= rec_d[j];
      end
      acc1_q  <= acc1_d;
      dd1_q   <= dd1_d;
      maxl1_q <= maxl0_q;
      k2_q    <= k2_d;
      k3_q    <= k2_q;
      ad2_q   <= ad2_d;
      v1_q    <= v1_d;
      lo4_q   <= lo4_d;
      hi4_q   <= hi4_d;
      pv6_q   <= pv6_d;
      r19_q   <= r19_d;
      sz20_q  <= sz20_d;
    end
  end

  psu_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .life_i (rec_q[1].life[30:0]),
    .maxl_i (maxl1_q),
    .q_o    (q18)
  );

  assign valid_o     = vld_q[Last];
  assign alive_out_o = rec_q[Last].alive;
  assign life_out_o  = rec_q[Last].life;
  assign pos_x_out_o = rec_q[Last].pos[0];
  assign pos_y_out_o = rec_q[Last].pos[1];
  assign pos_z_out_o = rec_q[Last].pos[2];
  assign vel_x_out_o = rec_q[Last].vel[0];
  assign vel_y_out_o = rec_q[Last].vel[1];
  assign vel_z_out_o = rec_q[Last].vel[2];
  assign size_out_o  = rec_q[Last].size;

endmodule

>>> rtl/psu_div.sv
// Pipelined restoring divider that forms the clamped life to lifetime ratio, one bit per stage.
module psu_div (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [psu_pkg::MaxLifeW-1:0]         life_i,
  input  logic [psu_pkg::MaxLifeW-1:0]         maxl_i,
  output logic [psu_pkg::QuoW:0]               q_o
);

  localparam int unsigned N = psu_pkg::QuoW;
  localparam int unsigned W = psu_pkg::MaxLifeW;

  logic [W-1:0]  rem_q  [0:N];
  logic [W-1:0]  m_q    [0:N];
  logic [N-1:0]  quo_q  [0:N];
  logic          full_q [0:N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= life_i;
      m_q[0]    <= maxl_i;
      quo_q[0]  <= '0;
      full_q[0] <= (life_i >= maxl_i);
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [W:0] trial;
    logic       take;
    assign trial = {rem_q[j], 1'b0};
    assign take  = (trial >= {1'b0, m_q[j]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= take ? W'(trial - {1'b0, m_q[j]}) : trial[W-1:0];
        m_q[j+1]    <= m_q[j];
        quo_q[j+1]  <= {quo_q[j][N-2:0], take};
        full_q[j+1] <= full_q[j];
      end
    end
  end

  assign q_o = full_q[N] ? (N+1)'(1 << N) : {1'b0, quo_q[N]};

endmodule
